// ----- sv/ntba_pkg.sv -----
// ---------------------------------------------------------------------------
// ntba_pkg
// Shared constants and types for the tagged block allocator.
// ---------------------------------------------------------------------------
package ntba_pkg;

    localparam int STORE_BYTES  = 4096;
    localparam int MEM_COUNT    = 2;
    localparam int HEADER_BYTES = 6;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int MEM_W        = $clog2(MEM_COUNT);
    localparam int DEPTH        = STORE_BYTES * MEM_COUNT;
    localparam int DEPTH_W      = $clog2(DEPTH);
    // walk positions can run past the store end by a full 16-bit size
    localparam int POS_W        = ADDR_W + 5;

    localparam logic [7:0]  ERASED   = 8'hff;
    localparam logic [15:0] FREE_TAG = 16'hffff;
    localparam logic [2:0]  SIG_BYTES = 3'd4;

    localparam logic [2:0] ACT_ALLOC   = 3'd0;
    localparam logic [2:0] ACT_RELEASE = 3'd1;
    localparam logic [2:0] ACT_CHECK   = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_WRITE   = 3'd4;

    localparam logic [1:0] ST_EXISTS  = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    localparam logic [1:0] CFG_SIGNATURE = 2'd0;
    localparam logic [1:0] CFG_PRI_ZERO  = 2'd1;
    localparam logic [1:0] CFG_PRI_ONE   = 2'd2;

    typedef struct packed {
        logic               we;
        logic [DEPTH_W-1:0] waddr;
        logic [7:0]         wdata;
        logic [DEPTH_W-1:0] raddr;
    } mem_req_t;

endpackage

// ----- sv/nvram_tagged_block_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// nvram_tagged_block_allocator_unit
// Tagged block allocator over two byte stores, one byte access per cycle.
// ---------------------------------------------------------------------------
// Reset: an erase pass writes 0xff to all 8192 bytes, one per cycle; no item
//   is taken during the pass. Configuration writes are taken always.
// Allocate walks the headers of each store; the first allocate first checks
//   both stores and rewrites any whose signature does not match, as a check does.
// Release moves the bytes after the block down, then fills the freed tail with 0xff.
// One item at a time: in_stall is high whenever the unit is not idle.
module nvram_tagged_block_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic        memory_index,
    input  logic [11:0] position,
    input  logic [11:0] request_size,
    input  logic [15:0] module_sig,
    input  logic [7:0]  block_id,
    input  logic [7:0]  version,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        result_memory,
    output logic [11:0] offset,
    output logic [7:0]  read_data
);

    localparam int AW = ntba_pkg::ADDR_W;
    localparam int PW = ntba_pkg::POS_W;
    localparam int CW = ntba_pkg::DEPTH_W;
    localparam logic [PW-1:0] WALK_END =
        PW'(ntba_pkg::STORE_BYTES - ntba_pkg::HEADER_BYTES);
    localparam logic [PW-1:0] WALK_START = PW'(ntba_pkg::SIG_BYTES);
    localparam logic [PW-1:0] STORE_END = PW'(ntba_pkg::STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ntba_pkg::STORE_BYTES - 1);
    localparam logic [CW-1:0] LAST_CELL = CW'(ntba_pkg::DEPTH - 1);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHK_RD  = 4'd2;
    localparam logic [3:0] S_CHK_WR  = 4'd3;
    localparam logic [3:0] S_WALK    = 4'd4;
    localparam logic [3:0] S_HDR     = 4'd5;
    localparam logic [3:0] S_EVAL    = 4'd6;
    localparam logic [3:0] S_CWR     = 4'd7;
    localparam logic [3:0] S_COPY_RD = 4'd8;
    localparam logic [3:0] S_COPY_WR = 4'd9;
    localparam logic [3:0] S_FILL    = 4'd10;
    localparam logic [3:0] S_READ    = 4'd11;
    localparam logic [3:0] S_READ_W  = 4'd12;
    localparam logic [3:0] S_WRITE   = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    localparam logic [1:0] MODE_FIND  = 2'd0;
    localparam logic [1:0] MODE_CARVE = 2'd1;
    localparam logic [1:0] MODE_REL   = 2'd2;

    ntba_pkg::mem_req_t mem_req;
    logic [7:0] rd_q;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          cur_reg, cur_next;
    logic [1:0]    mode_reg, mode_next;
    logic          alloc_chk_reg, alloc_chk_next;
    logic          second_reg, second_next;
    logic          fc_reg, fc_next;
    logic          mis_reg, mis_next;
    logic [PW-1:0] walk_reg, walk_next;
    logic [PW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [AW-1:0] cblk_reg, cblk_next;
    logic [7:0]    hdr_reg [6];
    logic [7:0]    hdr_next [6];
    logic [31:0]   sig_reg;
    logic [7:0]    pri0_reg, pri1_reg;
    logic [11:0]   op_pos_reg, op_pos_next;
    logic [11:0]   op_siz_reg, op_siz_next;
    logic [15:0]   op_tag_reg, op_tag_next;
    logic [7:0]    op_id_reg, op_id_next;
    logic [7:0]    op_ver_reg, op_ver_next;
    logic [7:0]    op_wd_reg, op_wd_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          res_mem_reg, res_mem_next;
    logic [11:0]   res_off_reg, res_off_next;
    logic [7:0]    res_rd_reg, res_rd_next;
    logic          ov_reg, ov_next;
    logic [1:0]    ost_reg, ost_next;
    logic          omem_reg, omem_next;
    logic [11:0]   ooff_reg, ooff_next;
    logic [7:0]    ord_reg, ord_next;

    logic          chk_end, walk_fail;
    logic [1:0]    sig_idx;
    logic [15:0]   h_tag, h_blk;
    logic [PW-1:0] blk_len, rel_src;
    logic [AW-1:0] rem, hdr_addr;
    logic [CW-1:0] fill_start;

    ntba_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rd_q)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = ov_reg;
    assign status        = ost_reg;
    assign result_memory = omem_reg;
    assign offset        = ooff_reg;
    assign read_data     = ord_reg;

    assign h_tag    = {hdr_reg[1], hdr_reg[0]};
    assign h_blk    = {hdr_reg[5], hdr_reg[4]};
    assign blk_len  = PW'(h_blk) + PW'(ntba_pkg::HEADER_BYTES);
    assign rel_src  = walk_reg + blk_len;
    assign rem      = AW'(WALK_END - walk_reg);
    assign hdr_addr = walk_reg[AW-1:0] + cnt_reg[AW-1:0];
    assign fill_start = (blk_len >= STORE_END) ? '0 : CW'(STORE_END - blk_len);

    always_comb
    begin
        state_next = state_reg;  cnt_next = cnt_reg;  cur_next = cur_reg;
        mode_next = mode_reg;  alloc_chk_next = alloc_chk_reg;
        second_next = second_reg;  fc_next = fc_reg;  mis_next = mis_reg;
        walk_next = walk_reg;  src_next = src_reg;  dst_next = dst_reg;
        cblk_next = cblk_reg;  hdr_next = hdr_reg;
        op_pos_next = op_pos_reg;
        op_siz_next = op_siz_reg;  op_tag_next = op_tag_reg;
        op_id_next = op_id_reg;  op_ver_next = op_ver_reg;  op_wd_next = op_wd_reg;
        res_st_next = res_st_reg;  res_mem_next = res_mem_reg;
        res_off_next = res_off_reg;  res_rd_next = res_rd_reg;
        ov_next = ov_reg;  ost_next = ost_reg;  omem_next = omem_reg;
        ooff_next = ooff_reg;  ord_next = ord_reg;
        mem_req = '0;
        chk_end = 1'b0;
        walk_fail = 1'b0;
        sig_idx = cnt_reg[1:0] - 2'd1;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                mem_req.wdata = ntba_pkg::ERASED;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_pos_next = position;
                    op_siz_next = request_size;  op_tag_next = module_sig;
                    op_id_next = block_id;  op_ver_next = version;
                    op_wd_next = write_data;
                    res_st_next = ntba_pkg::ST_DONE;  res_mem_next = 1'b0;
                    res_off_next = '0;  res_rd_next = '0;
                    cnt_next = '0;
                    mis_next = 1'b0;
                    cur_next = memory_index;
                    unique case (action)
                        ntba_pkg::ACT_ALLOC:
                        begin
                            cur_next = 1'b0;
                            if (!fc_reg)
                            begin
                                fc_next = 1'b1;
                                alloc_chk_next = 1'b1;
                                state_next = S_CHK_RD;
                            end
                            else
                            begin
                                mode_next  = MODE_FIND;
                                walk_next  = WALK_START;
                                state_next = S_WALK;
                            end
                        end
                        ntba_pkg::ACT_RELEASE:
                        begin
                            if (PW'(position) > WALK_END)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mode_next  = MODE_REL;
                                walk_next  = PW'(position);
                                state_next = S_HDR;
                            end
                        end
                        ntba_pkg::ACT_CHECK:
                        begin
                            alloc_chk_next = 1'b0;
                            state_next = S_CHK_RD;
                        end
                        ntba_pkg::ACT_READ:  state_next = S_READ;
                        ntba_pkg::ACT_WRITE: state_next = S_WRITE;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_CHK_RD:
            begin
                mem_req.raddr = {cur_reg, cnt_reg[AW-1:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0 && rd_q != sig_reg[8*sig_idx +: 8])
                begin
                    mis_next = 1'b1;
                end
                if (cnt_reg[2:0] == ntba_pkg::SIG_BYTES)
                begin
                    cnt_next = '0;
                    if (mis_reg || rd_q != sig_reg[8*sig_idx +: 8])
                    begin
                        state_next = S_CHK_WR;
                    end
                    else
                    begin
                        chk_end = 1'b1;
                    end
                end
            end
            S_CHK_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {cur_reg, cnt_reg[AW-1:0]};
                mem_req.wdata = (cnt_reg[AW-1:0] < AW'(ntba_pkg::SIG_BYTES)) ?
                                sig_reg[8*cnt_reg[1:0] +: 8] : ntba_pkg::ERASED;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[AW-1:0] == LAST_ADDR)
                begin
                    chk_end = 1'b1;
                end
            end
            S_WALK:
            begin
                cnt_next = '0;
                if (walk_reg >= WALK_END)
                begin
                    walk_fail = 1'b1;
                end
                else
                begin
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                mem_req.raddr = {cur_reg, hdr_addr};
                if (cnt_reg != '0)
                begin
                    hdr_next[cnt_reg[2:0] - 3'd1] = rd_q;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[2:0] == 3'(ntba_pkg::HEADER_BYTES))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cnt_next = '0;
                unique case (mode_reg)
                    MODE_FIND:
                    begin
                        if (h_tag == ntba_pkg::FREE_TAG)
                        begin
                            walk_fail = 1'b1;
                        end
                        else if (h_tag == op_tag_reg && hdr_reg[2] == op_id_reg &&
                                 hdr_reg[3] == op_ver_reg && h_blk >= 16'(op_siz_reg))
                        begin
                            res_st_next  = ntba_pkg::ST_EXISTS;
                            res_mem_next = cur_reg;
                            res_off_next = walk_reg[AW-1:0] + AW'(ntba_pkg::HEADER_BYTES);
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            walk_next  = walk_reg + blk_len;
                            state_next = S_WALK;
                        end
                    end
                    MODE_CARVE:
                    begin
                        if (h_tag == ntba_pkg::FREE_TAG)
                        begin
                            if (rem < op_siz_reg)
                            begin
                                walk_fail = 1'b1;
                            end
                            else
                            begin
                                cblk_next = (rem - op_siz_reg < AW'(ntba_pkg::HEADER_BYTES)) ?
                                            rem : op_siz_reg;
                                res_off_next = walk_reg[AW-1:0] + AW'(ntba_pkg::HEADER_BYTES);
                                state_next = S_CWR;
                            end
                        end
                        else
                        begin
                            walk_next  = walk_reg + blk_len;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        src_next = rel_src;
                        dst_next = walk_reg[AW-1:0];
                        cnt_next = fill_start;
                        state_next = (rel_src < STORE_END) ? S_COPY_RD : S_FILL;
                    end
                endcase
            end
            S_CWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {cur_reg, hdr_addr};
                unique case (cnt_reg[2:0])
                    3'd0:    mem_req.wdata = op_tag_reg[7:0];
                    3'd1:    mem_req.wdata = op_tag_reg[15:8];
                    3'd2:    mem_req.wdata = op_id_reg;
                    3'd3:    mem_req.wdata = op_ver_reg;
                    3'd4:    mem_req.wdata = cblk_reg[7:0];
                    default: mem_req.wdata = 8'(cblk_reg[AW-1:8]);
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[2:0] == 3'(ntba_pkg::HEADER_BYTES - 1))
                begin
                    res_st_next  = ntba_pkg::ST_NEW;
                    res_mem_next = cur_reg;
                    state_next   = S_DONE;
                end
            end
            S_COPY_RD:
            begin
                mem_req.raddr = {cur_reg, src_reg[AW-1:0]};
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {cur_reg, dst_reg};
                mem_req.wdata = rd_q;
                src_next = src_reg + 1'b1;
                dst_next = dst_reg + 1'b1;
                state_next = (src_reg[AW-1:0] == LAST_ADDR) ? S_FILL : S_COPY_RD;
            end
            S_FILL:
            begin
                if (cnt_reg[AW])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = {cur_reg, cnt_reg[AW-1:0]};
                    mem_req.wdata = ntba_pkg::ERASED;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_READ:
            begin
                mem_req.raddr = {cur_reg, op_pos_reg};
                state_next = S_READ_W;
            end
            S_READ_W:
            begin
                res_rd_next = rd_q;
                state_next  = S_DONE;
            end
            S_WRITE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {cur_reg, op_pos_reg};
                mem_req.wdata = op_wd_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    omem_next  = res_mem_reg;
                    ooff_next  = res_off_reg;
                    ord_next   = res_rd_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // a store check finished: next store, start of allocate, or done
        if (chk_end)
        begin
            cnt_next = '0;
            mis_next = 1'b0;
            if (alloc_chk_reg && !cur_reg)
            begin
                cur_next   = 1'b1;
                state_next = S_CHK_RD;
            end
            else if (alloc_chk_reg)
            begin
                cur_next   = 1'b0;
                mode_next  = MODE_FIND;
                walk_next  = WALK_START;
                state_next = S_WALK;
            end
            else
            begin
                state_next = S_DONE;
            end
        end

        // header walk ended without a result in this store
        if (walk_fail)
        begin
            walk_next  = WALK_START;
            state_next = S_WALK;
            if (mode_reg == MODE_FIND)
            begin
                if (!cur_reg)
                begin
                    cur_next = 1'b1;
                end
                else
                begin
                    mode_next   = MODE_CARVE;
                    second_next = 1'b0;
                    cur_next    = (pri1_reg > pri0_reg);
                end
            end
            else if (!second_reg)
            begin
                second_next = 1'b1;
                cur_next    = ~cur_reg;
            end
            else
            begin
                res_st_next  = ntba_pkg::ST_NOSPACE;
                res_mem_next = 1'b0;
                res_off_next = '0;
                state_next   = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;  cnt_reg <= '0;  cur_reg <= 1'b0;
            mode_reg <= MODE_FIND;  alloc_chk_reg <= 1'b0;  second_reg <= 1'b0;
            fc_reg <= 1'b0;  mis_reg <= 1'b0;  ov_reg <= 1'b0;
            sig_reg <= '0;  pri0_reg <= 8'd1;  pri1_reg <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;  cnt_reg <= cnt_next;  cur_reg <= cur_next;
            mode_reg <= mode_next;  alloc_chk_reg <= alloc_chk_next;
            second_reg <= second_next;  fc_reg <= fc_next;  mis_reg <= mis_next;
            ov_reg <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ntba_pkg::CFG_SIGNATURE: sig_reg  <= cfg_data;
                    ntba_pkg::CFG_PRI_ZERO:  pri0_reg <= cfg_data[7:0];
                    ntba_pkg::CFG_PRI_ONE:   pri1_reg <= cfg_data[7:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;  src_reg <= src_next;  dst_reg <= dst_next;
        cblk_reg <= cblk_next;  hdr_reg <= hdr_next;
        op_pos_reg <= op_pos_next;
        op_siz_reg <= op_siz_next;  op_tag_reg <= op_tag_next;
        op_id_reg <= op_id_next;  op_ver_reg <= op_ver_next;  op_wd_reg <= op_wd_next;
        res_st_reg <= res_st_next;  res_mem_reg <= res_mem_next;
        res_off_reg <= res_off_next;  res_rd_reg <= res_rd_next;
        ost_reg <= ost_next;  omem_reg <= omem_next;
        ooff_reg <= ooff_next;  ord_reg <= ord_next;
    end

endmodule

// ----- sv/ntba_store.sv -----
// ---------------------------------------------------------------------------
// ntba_store
// Byte array holding all stores: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ntba_store (
    input  logic                clk,
    input  ntba_pkg::mem_req_t  req,
    output logic [7:0]          rdata
);

    logic [7:0] mem [ntba_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ----- tb/tb_nvram_tagged_block_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// tb_nvram_tagged_block_allocator_unit
// Self-checking bench: a scoreboard class mirrors both byte stores and
// predicts every result; random traffic with idle gaps and output stalls.
// ---------------------------------------------------------------------------
module tb_nvram_tagged_block_allocator_unit;

    localparam int SB        = ntba_pkg::STORE_BYTES;
    localparam int HB        = ntba_pkg::HEADER_BYTES;
    localparam int CYC_LIMIT = 40000000;

    typedef struct {
        logic [2:0]  action;
        logic        mem;
        logic [11:0] pos;
        logic [11:0] size;
        logic [15:0] tag;
        logic [7:0]  id;
        logic [7:0]  ver;
        logic [7:0]  wdata;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic        mem;
        logic [11:0] offset;
        logic [7:0]  rdata;
    } answer_t;

    class alloc_scoreboard;
        logic [7:0]  store[ntba_pkg::MEM_COUNT][SB];
        bit          fmt_done;
        logic [31:0] sig;
        int          pri0;
        int          pri1;
        answer_t     pending[$];
        int          errors;

        function new();
            foreach (store[m, a]) store[m][a] = ntba_pkg::ERASED;
            fmt_done = 0;
            sig = 0;
            pri0 = 1;
            pri1 = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == ntba_pkg::CFG_SIGNATURE) sig = val;
            else if (idx == ntba_pkg::CFG_PRI_ZERO) pri0 = int'(val[7:0]);
            else if (idx == ntba_pkg::CFG_PRI_ONE) pri1 = int'(val[7:0]);
        endfunction

        function int rd(int m, int a);
            if (a >= SB) return int'(ntba_pkg::ERASED);
            return int'(store[m][a]);
        endfunction

        function int rd16(int m, int a);
            return rd(m, a) | (rd(m, a + 1) << 8);
        endfunction

        function void wr(int m, int a, int v);
            if (a < SB) store[m][a] = v[7:0];
        endfunction

        function int prio(int m);
            return (m == 0) ? pri0 : pri1;
        endfunction

        function void fix_store(int m);
            bit ok;
            ok = 1;
            for (int k = 0; k < 4; k++)
                if (rd(m, k) != int'(sig[8*k +: 8])) ok = 0;
            if (!ok) begin
                for (int k = 0; k < 4; k++) wr(m, k, int'(sig[8*k +: 8]));
                for (int k = 4; k < SB; k++) wr(m, k, int'(ntba_pkg::ERASED));
            end
        endfunction

        // used headers of a store, for picking release targets
        function void list_headers(int m, ref int hq[$]);
            int p;
            hq.delete();
            p = 4;
            while (p < SB - HB && rd16(m, p) != int'(ntba_pkg::FREE_TAG)) begin
                hq.push_back(p);
                p += rd16(m, p + 4) + HB;
            end
        endfunction

        function bit find_block(int m, request_t r, output int off);
            int p, blk;
            p = 4;
            off = 0;
            while (p < SB - HB) begin
                if (rd16(m, p) == int'(ntba_pkg::FREE_TAG)) break;
                blk = rd16(m, p + 4);
                if (rd16(m, p) == int'(r.tag) && rd(m, p + 2) == int'(r.id)
                    && rd(m, p + 3) == int'(r.ver) && blk >= int'(r.size)) begin
                    off = p + HB;
                    return 1;
                end
                p += blk + HB;
            end
            return 0;
        endfunction

        function bit carve(int m, request_t r, output int off);
            int p, rem, blk;
            p = 4;
            off = 0;
            while (p < SB - HB) begin
                if (rd16(m, p) == int'(ntba_pkg::FREE_TAG)) begin
                    rem = SB - (p + HB);
                    blk = int'(r.size);
                    if (rem < int'(r.size)) return 0;
                    // leftover smaller than a header goes to this block
                    if (rem - int'(r.size) < HB) blk = rem;
                    wr(m, p, int'(r.tag[7:0]));
                    wr(m, p + 1, int'(r.tag[15:8]));
                    wr(m, p + 2, int'(r.id));
                    wr(m, p + 3, int'(r.ver));
                    wr(m, p + 4, blk & 8'hff);
                    wr(m, p + 5, (blk >> 8) & 8'hff);
                    off = p + HB;
                    return 1;
                end
                p += rd16(m, p + 4) + HB;
            end
            return 0;
        endfunction

        function void free_block(int m, int p);
            int len, src, dst, fill;
            if (p > SB - HB) return;
            len = rd16(m, p + 4) + HB;
            src = p + len;
            dst = p;
            while (src < SB) begin
                wr(m, dst, rd(m, src));
                dst++;
                src++;
            end
            fill = (len >= SB) ? 0 : SB - len;
            while (fill < SB) begin
                wr(m, fill, int'(ntba_pkg::ERASED));
                fill++;
            end
        endfunction

        function void note_input(request_t r);
            answer_t e;
            int off, last, pri;
            bit done;
            e.status = ntba_pkg::ST_DONE;
            e.mem = 0;
            e.offset = 0;
            e.rdata = 0;
            case (r.action)
                ntba_pkg::ACT_ALLOC: begin
                    done = 0;
                    if (!fmt_done) begin
                        fmt_done = 1;
                        for (int i = 0; i < ntba_pkg::MEM_COUNT; i++) fix_store(i);
                    end
                    for (int i = 0; i < ntba_pkg::MEM_COUNT && !done; i++)
                        if (find_block(i, r, off)) begin
                            e.status = ntba_pkg::ST_EXISTS;
                            e.mem = 1'(i);
                            e.offset = 12'(off);
                            done = 1;
                        end
                    if (!done) begin
                        last = 999;
                        e.status = ntba_pkg::ST_NOSPACE;
                        while (!done) begin
                            pri = -1;
                            for (int i = 0; i < ntba_pkg::MEM_COUNT; i++)
                                if (prio(i) > pri && prio(i) < last) pri = prio(i);
                            if (pri < 0) break;
                            last = pri;
                            for (int i = 0; i < ntba_pkg::MEM_COUNT && !done; i++)
                                if (prio(i) == pri && carve(i, r, off)) begin
                                    e.status = ntba_pkg::ST_NEW;
                                    e.mem = 1'(i);
                                    e.offset = 12'(off);
                                    done = 1;
                                end
                        end
                    end
                end
                ntba_pkg::ACT_RELEASE: free_block(int'(r.mem), int'(r.pos));
                ntba_pkg::ACT_CHECK:   fix_store(int'(r.mem));
                ntba_pkg::ACT_READ:    e.rdata = 8'(rd(int'(r.mem), int'(r.pos)));
                ntba_pkg::ACT_WRITE:   wr(int'(r.mem), int'(r.pos), int'(r.wdata));
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(answer_t got);
            answer_t e;
            if (pending.size() == 0) begin
                report("result with nothing outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.mem !== e.mem)
                report($sformatf("result_memory %0d, want %0d", got.mem, e.mem));
            if (got.offset !== e.offset)
                report($sformatf("offset %0d, want %0d", got.offset, e.offset));
            if (got.rdata !== e.rdata)
                report($sformatf("read_data %0h, want %0h", got.rdata, e.rdata));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic        memory_index;
    logic [11:0] position;
    logic [11:0] request_size;
    logic [15:0] module_sig;
    logic [7:0]  block_id;
    logic [7:0]  version;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        result_memory;
    logic [11:0] offset;
    logic [7:0]  read_data;

    alloc_scoreboard sb;
    int              cycles;
    int              data_spots[$];
    bit              stall_on;

    nvram_tagged_block_allocator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .memory_index(memory_index), .position(position),
        .request_size(request_size), .module_sig(module_sig),
        .block_id(block_id), .version(version), .write_data(write_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_memory(result_memory),
        .offset(offset), .read_data(read_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(100, 20);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("[nvram_tagged_block_allocator_unit] ERROR");
            $finish;
        end
        if (out_valid && !out_stall) begin
            answer_t got;
            got.status = status;
            got.mem = result_memory;
            got.offset = offset;
            got.rdata = read_data;
            sb.check_result(got);
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!stall_on) out_stall <= 1'b0;
        else if ($urandom_range(99) < 25) out_stall <= 1'b1;
        else if ($urandom_range(99) < 3) out_stall <= 1'b1;
        else out_stall <= 1'b0;
    end

    task cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    // caller is at a falling edge; returns at a falling edge after the transfer and any idle gap
    task send(request_t r);
        int gap;
        action = r.action;
        memory_index = r.mem;
        position = r.pos;
        request_size = r.size;
        module_sig = r.tag;
        block_id = r.id;
        version = r.ver;
        write_data = r.wdata;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(r);
        if (r.action == ntba_pkg::ACT_ALLOC && sb.pending[$].status != ntba_pkg::ST_NOSPACE)
            data_spots.push_back(int'({sb.pending[$].mem, sb.pending[$].offset}));
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function request_t blank(logic [2:0] act);
        request_t r;
        r.action = act;
        r.mem = 1'($urandom_range(1));
        r.pos = 12'($urandom);
        r.size = 12'($urandom);
        r.tag = 16'($urandom);
        r.id = 8'($urandom);
        r.ver = 8'($urandom);
        r.wdata = 8'($urandom);
        return r;
    endfunction

    function request_t alloc_req(int sz);
        request_t r;
        r = blank(ntba_pkg::ACT_ALLOC);
        r.size = 12'(sz);
        return r;
    endfunction

    function request_t at_req(logic [2:0] act, logic m, int p);
        request_t r;
        r = blank(act);
        r.mem = m;
        r.pos = 12'(p);
        return r;
    endfunction

    task drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function request_t random_req();
        request_t r;
        int sel, hq[$], spot;
        sel = $urandom_range(99);
        if (sel < 40) begin
            r = blank(ntba_pkg::ACT_ALLOC);
            // small tag pool so existing blocks get found again
            if ($urandom_range(3) != 0) begin
                r.tag = 16'($urandom_range(3));
                r.id = 8'($urandom_range(1));
                r.ver = 8'($urandom_range(1));
            end
            if ($urandom_range(19) == 0) r.size = 12'($urandom);
            else r.size = 12'($urandom_range(80));
        end else if (sel < 60) begin
            r = blank(ntba_pkg::ACT_READ);
            if (data_spots.size() != 0 && $urandom_range(1)) begin
                spot = data_spots[$urandom_range(data_spots.size() - 1)];
                r.mem = spot[12];
                r.pos = 12'(spot[11:0] + $urandom_range(4));
            end
        end else if (sel < 84) begin
            r = blank(ntba_pkg::ACT_WRITE);
            if (data_spots.size() != 0 && $urandom_range(9) != 0) begin
                spot = data_spots[$urandom_range(data_spots.size() - 1)];
                r.mem = spot[12];
                r.pos = 12'(spot[11:0] + $urandom_range(4));
            end
        end else if (sel < 91) begin
            r = blank(ntba_pkg::ACT_RELEASE);
            sb.list_headers(int'(r.mem), hq);
            if (hq.size() != 0 && $urandom_range(7) != 0)
                r.pos = 12'(hq[$urandom_range(hq.size() - 1)]);
            else if ($urandom_range(1)) r.pos = 12'($urandom_range(4095, 4080));
        end else if (sel < 96) begin
            r = blank(ntba_pkg::ACT_CHECK);
        end else begin
            r = blank(3'($urandom_range(7, 5)));
        end
        return r;
    endfunction

    initial
    begin
        sb = new();
        cycles = 0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ntba_pkg::CFG_SIGNATURE;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = ntba_pkg::ACT_READ;
        memory_index = 1'b0;
        position = '0;
        request_size = '0;
        module_sig = '0;
        block_id = '0;
        version = '0;
        write_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset configuration; first allocate formats both stores
        send(at_req(ntba_pkg::ACT_READ, 1'b0, 0));
        send(at_req(ntba_pkg::ACT_WRITE, 1'b1, 4095));
        send(at_req(ntba_pkg::ACT_READ, 1'b1, 4095));
        send(alloc_req(0));
        send(alloc_req(4095));
        send(alloc_req(4086 - 10));
        send(alloc_req(1));
        send(alloc_req(0));
        send(at_req(ntba_pkg::ACT_READ, 1'b0, 4));
        send(at_req(ntba_pkg::ACT_RELEASE, 1'b0, 4091));
        send(at_req(ntba_pkg::ACT_RELEASE, 1'b0, 4090));
        send(at_req(ntba_pkg::ACT_CHECK, 1'b1, 0));
        send(at_req(3'd5, 1'b0, 0));
        send(at_req(3'd6, 1'b1, 0));
        send(at_req(3'd7, 1'b1, 0));
        begin
            request_t r;
            r = alloc_req(12);
            r.tag = 16'hffff;
            r.id = 8'hff;
            r.ver = 8'hff;
            send(r);
            r.tag = 16'h0000;
            r.id = 8'h00;
            r.ver = 8'h00;
            send(r);
            send(r);
        end
        // release at the first header position of store 0
        send(at_req(ntba_pkg::ACT_RELEASE, 1'b0, 4));
        stall_on = 1'b1;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            int pa, pb;
            case (ph)
                0: begin pa = 0;   pb = 0;   end
                1: begin pa = 255; pb = 255; end
                2: begin pa = 0;   pb = 255; end
                3: begin pa = 255; pb = 0;   end
                4: begin pa = 7;   pb = 7;   end
                default: begin pa = $urandom_range(255); pb = $urandom_range(255); end
            endcase
            cfg_write(ntba_pkg::CFG_SIGNATURE, (ph == 1) ? 32'hffffffff : $urandom);
            cfg_write(ntba_pkg::CFG_PRI_ZERO, pa);
            cfg_write(ntba_pkg::CFG_PRI_ONE, pb);
            data_spots.delete();
            @(negedge clk);
            // new signature: rewrite both stores
            send(at_req(ntba_pkg::ACT_CHECK, 1'b0, 0));
            send(at_req(ntba_pkg::ACT_CHECK, 1'b1, 0));
            for (int n = 0; n < 265; n++) begin
                send(random_req());
                if (n == 130) begin
                    in_valid = 1'b0;
                    while (sb.pending.size() != 0) @(negedge clk);
                end
            end
            drain();
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[nvram_tagged_block_allocator_unit] OK");
        else
            $display("[nvram_tagged_block_allocator_unit] ERROR");
        $finish;
    end

endmodule
